/* rtl/accent_probability_step_gate_top_assert.svh */
// Assertion macros used by the step gate top module.
`ifndef ACCENT_PROBABILITY_STEP_GATE_TOP_ASSERT_SVH
`define ACCENT_PROBABILITY_STEP_GATE_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define APSG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("step gate check failed");

// Check that a condition implies another in the next cycle.
`define APSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("step gate check failed");

`endif

/* rtl/apsg_pkg.sv */
// Shared types, constants and the divide-by-1023 helper for the step gate.
`default_nettype none

package apsg_pkg;

    localparam int TEX_W      = 10;
    localparam int STRENGTH_W = 3;
    localparam int CUT_W      = 17;

    localparam logic [CUT_W-1:0]      CUT_FULL     = 17'd65536;
    localparam logic [TEX_W-1:0]      TEX_MAX      = 10'd1023;
    localparam logic [STRENGTH_W-1:0] STRENGTH_MAX = 3'd4;

    typedef enum logic [1:0] {
        CLASS_PRIMARY   = 2'd0,
        CLASS_SECONDARY = 2'd1,
        CLASS_GHOST     = 2'd2
    } step_class_t;

    typedef enum logic [0:0] {
        REG_TEXTURE  = 1'b0,
        REG_STRENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [TEX_W-1:0]      texture;
        logic [STRENGTH_W-1:0] strength;
    } cfg_t;

    // Floor of x / 1023: fold the upper bits back in, since 1024 = 1023 + 1.
    // Three folds bring the remainder below twice the divisor.
    function automatic logic [16:0] div1023(input logic [25:0] x);
        logic [25:0] rem;
        logic [16:0] quo;
        logic [15:0] hi;
        rem = x;
        quo = '0;
        for (int i = 0; i < 3; i++)
        begin
            hi  = rem[25:10];
            quo = quo + 17'(hi);
            rem = 26'(hi) + 26'(rem[9:0]);
        end
        if (rem >= 26'(TEX_MAX))
        begin
            quo = quo + 17'd1;
        end
        return quo;
    endfunction

endpackage

`default_nettype wire

/* rtl/apsg_cfg_regs.sv */
// Configuration registers of the step gate: texture level and fill strength.
`default_nettype none

module apsg_cfg_regs (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [0:0]           wr_index,
    input  wire logic [9:0]           wr_data,
    output apsg_pkg::cfg_t            cfg
);
    import apsg_pkg::*;

    logic [TEX_W-1:0]      texture_reg;
    logic [TEX_W-1:0]      texture_next;
    logic [STRENGTH_W-1:0] strength_reg;
    logic [STRENGTH_W-1:0] strength_next;

    // Decode the register index of a write
    always_comb
    begin
        texture_next  = texture_reg;
        strength_next = strength_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_TEXTURE:  texture_next  = wr_data[TEX_W-1:0];
                REG_STRENGTH: strength_next = wr_data[STRENGTH_W-1:0];
                default:      texture_next  = texture_reg;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texture_reg  <= '0;
            strength_reg <= '0;
        end
        else
        begin
            texture_reg  <= texture_next;
            strength_reg <= strength_next;
        end
    end

    assign cfg.texture  = texture_reg;
    assign cfg.strength = strength_reg;

endmodule

`default_nettype wire

/* rtl/accent_probability_step_gate_top.sv */
// Accent probability step gate: four-register pipeline from step to hit decision.
// A step moves from stage a through b and c to the out stage. Throughput: one step per cycle
// while result_stall is low; each stage loads when it is empty or the one ahead moves,
// so a stalled result holds only full stages and the input stalls once all four are full.
// Reset: clears all valid flags and sets texture level and fill strength to zero.
`default_nettype none
`include "accent_probability_step_gate_top_assert.svh"

module accent_probability_step_gate_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [0:0]  wr_index,
    input  wire logic [9:0]  wr_data,
    input  wire logic        step_valid,
    output      logic        step_stall,
    input  wire logic [3:0]  step_index,
    input  wire logic [15:0] random_word,
    input  wire logic        fill_bar,
    input  wire logic        final_quarter,
    output      logic        result_valid,
    input  wire logic        result_stall,
    output      logic        hit,
    output      logic [1:0]  step_class,
    output      logic [16:0] cutoff
);
    import apsg_pkg::*;

    cfg_t cfg;

    apsg_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Pipeline valid flags
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic c_valid_reg, c_valid_next;
    logic out_valid_reg, out_valid_next;

    // Stage payloads
    logic [3:0]       a_step_reg;
    logic [15:0]      a_rnd_reg;
    logic             a_fill_reg;
    logic             a_last_reg;

    step_class_t      b_class_reg, b_class_next;
    logic [15:0]      b_rnd_reg;
    logic [CUT_W-1:0] b_sec_reg, b_sec_next;
    logic [19:0]      b_sq_reg, b_sq_next;
    logic [CUT_W-1:0] b_boost_reg, b_boost_next;

    step_class_t      c_class_reg;
    logic [15:0]      c_rnd_reg;
    logic [CUT_W-1:0] c_sec_reg;
    logic [25:0]      c_m_reg, c_m_next;
    logic [CUT_W-1:0] c_boost_reg;

    logic             hit_reg, hit_next;
    step_class_t      class_reg;
    logic [CUT_W-1:0] cutoff_reg, cutoff_next;

    // Advance enables, from the result side back to the input
    logic out_load, c_load, b_load, a_load;

    assign out_load   = !out_valid_reg || !result_stall;
    assign c_load     = !c_valid_reg || out_load;
    assign b_load     = !b_valid_reg || c_load;
    assign a_load     = !a_valid_reg || b_load;
    assign step_stall = !a_load;

    assign a_valid_next   = a_load   ? step_valid  : a_valid_reg;
    assign b_valid_next   = b_load   ? a_valid_reg : b_valid_reg;
    assign c_valid_next   = c_load   ? b_valid_reg : c_valid_reg;
    assign out_valid_next = out_load ? c_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Classify the step, scale texture for the secondary cutoff, square it, size the boost
    logic [15:0]           tex_x64;
    logic [STRENGTH_W-1:0] strength_lim;
    logic [15:0]           boost_unit;

    always_comb
    begin
        unique case (a_step_reg[1:0]) inside
            2'b00:        b_class_next = CLASS_PRIMARY;
            2'b10:        b_class_next = CLASS_SECONDARY;
            2'b01, 2'b11: b_class_next = CLASS_GHOST;
            default:      b_class_next = CLASS_GHOST;
        endcase

        tex_x64    = {cfg.texture, 6'b0};
        b_sec_next = 17'(tex_x64) + div1023(26'(tex_x64));
        b_sq_next  = {10'b0, cfg.texture} * {10'b0, cfg.texture};

        strength_lim = (cfg.strength > STRENGTH_MAX) ? STRENGTH_MAX : cfg.strength;
        boost_unit   = {strength_lim, 13'b0};
        if (!a_fill_reg)
        begin
            b_boost_next = '0;
        end
        else if (a_last_reg)
        begin
            b_boost_next = {boost_unit, 1'b0};
        end
        else
        begin
            b_boost_next = {1'b0, boost_unit};
        end
    end

    // First fold of the ghost division: texture squared times 32768 over 1023
    logic [24:0] sq_x32;

    always_comb
    begin
        sq_x32   = {b_sq_reg, 5'b0};
        c_m_next = 26'(sq_x32) + 26'(div1023({1'b0, sq_x32}));
    end

    // Finish the ghost division, apply the boost, saturate and compare
    logic [CUT_W-1:0] ghost_cut;
    logic [CUT_W-1:0] base_cut;
    logic [CUT_W:0]   boosted;

    always_comb
    begin
        ghost_cut = div1023(c_m_reg);
        base_cut  = (c_class_reg == CLASS_SECONDARY) ? c_sec_reg : ghost_cut;
        boosted   = {1'b0, base_cut} + {1'b0, c_boost_reg};
        if (c_class_reg == CLASS_PRIMARY)
        begin
            cutoff_next = CUT_FULL;
        end
        else if (boosted > {1'b0, CUT_FULL})
        begin
            cutoff_next = CUT_FULL;
        end
        else
        begin
            cutoff_next = boosted[CUT_W-1:0];
        end
        hit_next = (cutoff_next == CUT_FULL) || ({1'b0, c_rnd_reg} < cutoff_next);
    end

    // Stage payload registers
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_step_reg <= step_index;
            a_rnd_reg  <= random_word;
            a_fill_reg <= fill_bar;
            a_last_reg <= final_quarter;
        end
        if (b_load)
        begin
            b_class_reg <= b_class_next;
            b_rnd_reg   <= a_rnd_reg;
            b_sec_reg   <= b_sec_next;
            b_sq_reg    <= b_sq_next;
            b_boost_reg <= b_boost_next;
        end
        if (c_load)
        begin
            c_class_reg <= b_class_reg;
            c_rnd_reg   <= b_rnd_reg;
            c_sec_reg   <= b_sec_reg;
            c_m_reg     <= c_m_next;
            c_boost_reg <= b_boost_reg;
        end
        if (out_load)
        begin
            hit_reg    <= hit_next;
            class_reg  <= c_class_reg;
            cutoff_reg <= cutoff_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign hit          = hit_reg;
    assign step_class   = class_reg;
    assign cutoff       = cutoff_reg;

    // Checks on the result and the pipeline fill
    `APSG_ASSERT_SAME(a_primary_full, clk, rst_n,
        result_valid && (step_class == CLASS_PRIMARY), (cutoff == CUT_FULL) && hit)
    `APSG_ASSERT_SAME(a_cutoff_range, clk, rst_n, result_valid, cutoff <= CUT_FULL)
    `APSG_ASSERT_SAME(a_full_fires, clk, rst_n, result_valid && (cutoff == CUT_FULL), hit)
    `APSG_ASSERT_SAME(a_full_stalls, clk, rst_n,
        result_valid && result_stall && c_valid_reg && b_valid_reg && a_valid_reg,
        step_stall)
    `APSG_ASSERT_NEXT(a_stall_holds, clk, rst_n, result_valid && result_stall,
        result_valid && $stable(cutoff) && $stable(hit) && $stable(step_class))

endmodule

`default_nettype wire
